### sv/twbcc_pkg.sv
// shared types and constants for the three-way byte compose checker
// no dependencies; imported by three_way_byte_compose_checker_top
`timescale 1ns / 1ps

package twbcc_pkg;

  // fixed widths of the transaction fields
  localparam int unsigned ByteW   = 9;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned OutW    = 40;
  localparam int unsigned NumMetrics = 12;
  localparam int unsigned NumCtx  = 2;

  // configuration reset values
  localparam logic [CfgW-1:0] SectorSizeRst = 12'd2352;
  localparam logic [CfgW-1:0] UserStartRst  = 12'd24;
  localparam logic [CfgW-1:0] UserLengthRst = 12'd2048;

  typedef logic signed [ByteW-1:0] byte_t;

  typedef enum logic {
    OpPosition = 1'b0,
    OpFinish   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CfgSectorSize = 2'd0,
    CfgUserStart  = 2'd1,
    CfgUserLength = 2'd2
  } cfg_idx_e;

  // report order
  typedef enum logic [3:0] {
    IdTitleDelta       = 4'd0,
    IdScriptDelta      = 4'd1,
    IdCombinedDelta    = 4'd2,
    IdUserTitleDelta   = 4'd3,
    IdUserScriptDelta  = 4'd4,
    IdUserCombDelta    = 4'd5,
    IdOverlap          = 4'd6,
    IdConflictOverlap  = 4'd7,
    IdComposeMis       = 4'd8,
    IdUserOverlap      = 4'd9,
    IdUserConflict     = 4'd10,
    IdUserComposeMis   = 4'd11,
    IdTitleCtx         = 4'd12,
    IdScriptCtx        = 4'd13
  } metric_id_e;

endpackage

### sv/three_way_byte_compose_checker_top.sv
// three-way byte compose checker: per-position classification and statistics
// depends on twbcc_pkg (types, metric ids, configuration constants)
`timescale 1ns / 1ps

// timing: a position transaction updates the statistics in the cycle after acceptance;
//   a finish is held in the input register until the output register can load, which
//   then takes one report per cycle while out_ready_i is high (14 reports in all)
// throughput: one position per cycle while no finish is held; a finish holds the input
//   stage until the single output register has taken all 14 of its reports
// reset: asynchronous, active low; clears all statistics, loads 2352 / 24 / 2048
module three_way_byte_compose_checker_top #(
  parameter int unsigned COUNT_BITS = 40
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [11:0]               cfg_data_i,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      op_i,
  input  twbcc_pkg::byte_t          base_byte_i,
  input  twbcc_pkg::byte_t          title_byte_i,
  input  twbcc_pkg::byte_t          script_byte_i,
  input  twbcc_pkg::byte_t          combined_byte_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output twbcc_pkg::metric_id_e     metric_id_o,
  output logic [39:0]               byte_count_o,
  output logic [39:0]               sector_count_o,
  output logic [39:0]               run_total_o,
  output logic                      user_compose_ok_o,
  output logic                      last_in_report_o
);
  import twbcc_pkg::*;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : v + cnt_t'(1);
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers, always ready; writes beyond the list are dropped
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0] sector_size_q, user_start_q, user_length_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_size_q <= SectorSizeRst;
      user_start_q  <= UserStartRst;
      user_length_q <= UserLengthRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSectorSize: sector_size_q <= cfg_data_i;
        CfgUserStart:  user_start_q  <= cfg_data_i;
        CfgUserLength: user_length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic  in_valid_q;
  op_e   op_q;
  byte_t base_q, title_q, script_q, comb_q;
  logic  in_advance;

  assign in_ready_o = !in_valid_q || in_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q     <= op_e'(op_i);
      base_q   <= base_byte_i;
      title_q  <= title_byte_i;
      script_q <= script_byte_i;
      comb_q   <= combined_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // report sequencer and handshake control
  // a finish stays in the input register while its 14 reports go out,
  // the statistics are cleared when the last report is loaded
  // ---------------------------------------------------------------------------
  logic       out_load, rpt_fire, finish_done, pos_fire;
  logic [3:0] rpt_idx_q;

  assign out_load    = !out_valid_o || out_ready_i;
  assign rpt_fire    = in_valid_q && (op_q == OpFinish) && out_load;
  assign finish_done = rpt_fire && (rpt_idx_q == IdScriptCtx);
  assign pos_fire    = in_valid_q && (op_q == OpPosition);
  assign in_advance  = pos_fire || finish_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpt_idx_q <= 4'd0;
    end else if (finish_done) begin
      rpt_idx_q <= 4'd0;
    end else if (rpt_fire) begin
      rpt_idx_q <= rpt_idx_q + 4'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // classification of the held position
  // bytes compare as 9-bit patterns, so an ended stream is just another value
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0]       pis_q;
  logic [CfgW:0]         user_end, pis_next;
  logic                  in_user, sec_wrap;
  logic                  dt, ds, dc, ov, cov, mis;
  logic [NumMetrics-1:0] mark;

  assign dt  = title_q != base_q;
  assign ds  = script_q != base_q;
  assign dc  = comb_q != base_q;
  assign ov  = dt && ds;
  assign cov = ov && (title_q != script_q);
  assign mis = comb_q != (dt ? title_q : script_q);

  // window end computed one bit wider so it never wraps
  assign user_end = {1'b0, user_start_q} + {1'b0, user_length_q};
  assign in_user  = (pis_q >= user_start_q) && ({1'b0, pis_q} < user_end);

  assign mark[IdTitleDelta]      = dt;
  assign mark[IdScriptDelta]     = ds;
  assign mark[IdCombinedDelta]   = dc;
  assign mark[IdUserTitleDelta]  = in_user && dt;
  assign mark[IdUserScriptDelta] = in_user && ds;
  assign mark[IdUserCombDelta]   = in_user && dc;
  assign mark[IdOverlap]         = ov;
  assign mark[IdConflictOverlap] = cov;
  assign mark[IdComposeMis]      = mis;
  assign mark[IdUserOverlap]     = in_user && ov;
  assign mark[IdUserConflict]    = in_user && cov;
  assign mark[IdUserComposeMis]  = in_user && mis;

  // sector offset; a zero sector size wraps every position, like a size of one
  assign pis_next = {1'b0, pis_q} + 13'd1;
  assign sec_wrap = pis_next >= {1'b0, sector_size_q};

  // ---------------------------------------------------------------------------
  // statistics, one lane per metric
  // ---------------------------------------------------------------------------
  cnt_t                  bytes_q   [NumMetrics];
  cnt_t                  runs_q    [NumMetrics];
  cnt_t                  sectors_q [NumMetrics];
  cnt_t                  ctx_q     [NumCtx];
  logic [NumMetrics-1:0] prev_q, insec_q;

  cnt_t                  bytes_d   [NumMetrics];
  cnt_t                  runs_d    [NumMetrics];
  cnt_t                  sectors_d [NumMetrics];
  cnt_t                  ctx_d     [NumCtx];
  logic [NumMetrics-1:0] prev_d, insec_d;
  logic [CfgW-1:0]       pis_d;

  always_comb begin
    bytes_d   = bytes_q;
    runs_d    = runs_q;
    sectors_d = sectors_q;
    ctx_d     = ctx_q;
    prev_d    = prev_q;
    insec_d   = insec_q;
    pis_d     = pis_q;
    if (finish_done) begin
      // finish clears everything but the configuration
      for (int k = 0; k < NumMetrics; k++) begin
        bytes_d[k]   = '0;
        runs_d[k]    = '0;
        sectors_d[k] = '0;
      end
      for (int j = 0; j < NumCtx; j++) begin
        ctx_d[j] = '0;
      end
      prev_d  = '0;
      insec_d = '0;
      pis_d   = '0;
    end else if (pos_fire) begin
      for (int k = 0; k < NumMetrics; k++) begin
        if (mark[k]) begin
          bytes_d[k] = sat_inc(bytes_q[k]);
          if (!prev_q[k]) begin
            runs_d[k] = sat_inc(runs_q[k]);
          end
          if (!insec_q[k]) begin
            sectors_d[k] = sat_inc(sectors_q[k]);
          end
        end
      end
      prev_d = mark;
      // crossing into a new sector forgets which metrics were seen
      insec_d = sec_wrap ? '0 : (insec_q | mark);
      pis_d   = sec_wrap ? '0 : pis_next[CfgW-1:0];
      if (dt && (comb_q != title_q)) begin
        ctx_d[0] = sat_inc(ctx_q[0]);
      end
      if (ds && !dt && (comb_q != script_q)) begin
        ctx_d[1] = sat_inc(ctx_q[1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumMetrics; k++) begin
        bytes_q[k]   <= '0;
        runs_q[k]    <= '0;
        sectors_q[k] <= '0;
      end
      for (int j = 0; j < NumCtx; j++) begin
        ctx_q[j] <= '0;
      end
      prev_q  <= '0;
      insec_q <= '0;
      pis_q   <= '0;
    end else begin
      bytes_q   <= bytes_d;
      runs_q    <= runs_d;
      sectors_q <= sectors_d;
      ctx_q     <= ctx_d;
      prev_q    <= prev_d;
      insec_q   <= insec_d;
      pis_q     <= pis_d;
    end
  end

  // ---------------------------------------------------------------------------
  // report select and output register
  // counters are cut or zero-extended to the 40-bit report fields
  // ---------------------------------------------------------------------------
  logic [OutW-1:0] rpt_bytes, rpt_sectors, rpt_runs;
  logic            rpt_ok;

  always_comb begin
    rpt_bytes   = '0;
    rpt_sectors = '0;
    rpt_runs    = '0;
    if (rpt_idx_q < 4'(NumMetrics)) begin
      rpt_bytes   = OutW'(bytes_q[rpt_idx_q]);
      rpt_sectors = OutW'(sectors_q[rpt_idx_q]);
      rpt_runs    = OutW'(runs_q[rpt_idx_q]);
    end else begin
      // title context is the even id, script context the odd one
      rpt_bytes = OutW'(ctx_q[rpt_idx_q[0]]);
    end
  end

  assign rpt_ok = bytes_q[IdUserComposeMis] == '0;

  logic            out_valid_q;
  metric_id_e      metric_id_q;
  logic [OutW-1:0] byte_count_q, sector_count_q, run_total_q;
  logic            ok_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rpt_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rpt_fire) begin
      metric_id_q    <= metric_id_e'(rpt_idx_q);
      byte_count_q   <= rpt_bytes;
      sector_count_q <= rpt_sectors;
      run_total_q    <= rpt_runs;
      ok_q           <= rpt_ok;
      last_q         <= rpt_idx_q == IdScriptCtx;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign metric_id_o       = metric_id_q;
  assign byte_count_o      = byte_count_q;
  assign sector_count_o    = sector_count_q;
  assign run_total_o       = run_total_q;
  assign user_compose_ok_o = ok_q;
  assign last_in_report_o  = last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the report index only moves while a finish is held in the input register
  a_rpt_idx_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rpt_idx_q != 4'd0) |-> (in_valid_q && (op_q == OpFinish)))
    else $error("report index active without a finish transaction");

  a_rpt_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpt_idx_q <= IdScriptCtx)
    else $error("report index out of range");

  // statistics read zero right after a finish completes
  a_clear_after_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish_done |=> (bytes_q[IdUserComposeMis] == '0 && ctx_q[0] == '0 &&
                     pis_q == '0))
    else $error("statistics not cleared after finish");

  // the compose flag agrees with the user compose mismatch report
  a_ok_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && user_compose_ok_o && (metric_id_o == IdUserComposeMis))
      |-> (byte_count_o == '0))
    else $error("user compose flag disagrees with its byte count");

endmodule
